/* rtl/signed_int_seven_segment_scanner_top_defines.svh */
// Shared assertion macros
`ifndef SIGNED_INT_SEVEN_SEGMENT_SCANNER_TOP_DEFINES_SVH
`define SIGNED_INT_SEVEN_SEGMENT_SCANNER_TOP_DEFINES_SVH

// Check that a property holds on every clock edge outside reset
`define SSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle
`define SSS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* rtl/sss_pkg.sv */
`default_nettype none
package sss_pkg;

  localparam int unsigned NumDigits = 4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [3:0] CODE_ZERO  = 4'd0;
  localparam logic [3:0] CODE_MINUS = 4'd10;
  localparam logic [3:0] CODE_BLANK = 4'd15;

  localparam logic [7:0] GLYPH_ERROR = 8'h79;

  localparam logic [15:0] RECIP_TEN = 16'hCCCD;
  localparam int unsigned RecipShift = 19;

  localparam logic [2:0] LIMIT_POS = 3'd4;
  localparam logic [2:0] LIMIT_NEG = 3'd3;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] value;
  } in_req_t;

  typedef struct packed {
    logic [7:0] digit_select;
    logic [7:0] segments;
  } out_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } state_e;

  typedef struct packed {
    logic load_start;
    logic conv_step;
    logic tick_fire;
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] select_code(input logic [1:0] idx);
    logic [7:0] sel;
    case (idx)
      2'd0:    sel = 8'h88;
      2'd1:    sel = 8'h48;
      2'd2:    sel = 8'h28;
      2'd3:    sel = 8'h18;
      default: sel = 8'h88;
    endcase
    return sel;
  endfunction

  function automatic logic [7:0] seg_pattern(input logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'd0:    seg = 8'h3f;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5b;
      4'd3:    seg = 8'h4f;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6d;
      4'd6:    seg = 8'h7d;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7f;
      4'd9:    seg = 8'h6f;
      4'd10:   seg = 8'h40;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

/* rtl/signed_int_seven_segment_scanner_top.sv */
// Tick request: result registered in the cycle after acceptance, one tick per
// cycle when not stalled. Load request: one decimal digit per cycle through a
// reciprocal multiply-by-ten-inverse unit; input is stalled while a load converts.
// Loads are accepted while a tick result waits at the output.
// Reset clears digits to 0000, the error flag and the scan index.
`default_nettype none
module signed_int_seven_segment_scanner_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sss_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sss_pkg::out_req_t      out_req_o
);

  sss_pkg::cmd_t cmd;
  sss_pkg::sts_t sts;

  sss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_req_i.kind),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sss_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
`default_nettype wire

/* rtl/sss_ctrl.sv */
`default_nettype none
module sss_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_kind_i,
  output logic                  in_stall_o,
  input  wire sss_pkg::sts_t    sts_i,
  output sss_pkg::cmd_t         cmd_o
);

  `include "signed_int_seven_segment_scanner_top_defines.svh"

  sss_pkg::state_e state_q, state_d;
  logic            busy;
  logic            load_acc;
  logic            tick_acc;

  assign busy     = (state_q == sss_pkg::ST_CONV);
  assign load_acc = in_valid_i && !busy && (in_kind_i == sss_pkg::KIND_LOAD);
  assign tick_acc = in_valid_i && !busy && (in_kind_i == sss_pkg::KIND_TICK) && sts_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sss_pkg::ST_IDLE: begin
        if (load_acc) begin
          state_d = sss_pkg::ST_CONV;
        end
      end
      sss_pkg::ST_CONV: begin
        if (sts_i.conv_last) begin
          state_d = sss_pkg::ST_IDLE;
        end
      end
      default: state_d = sss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      sss_pkg::ST_IDLE: begin
        in_stall_o         = (in_kind_i == sss_pkg::KIND_TICK) && !sts_i.out_free;
        cmd_o.load_start   = load_acc;
        cmd_o.tick_fire    = tick_acc;
      end
      sss_pkg::ST_CONV: begin
        in_stall_o      = 1'b1;
        cmd_o.conv_step = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  `SSS_ASSERT(a_conv_stalls, busy |-> in_stall_o, "input accepted during conversion")
  `SSS_ASSERT_NEXT(a_load_enters_conv, load_acc, state_q == sss_pkg::ST_CONV,
                   "load did not start conversion")
  `SSS_ASSERT(a_one_cmd, $onehot0({cmd_o.load_start, cmd_o.conv_step, cmd_o.tick_fire}),
              "conflicting datapath commands")

endmodule
`default_nettype wire

/* rtl/sss_dpath.sv */
`default_nettype none
module sss_dpath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sss_pkg::in_req_t  in_req_i,
  input  wire sss_pkg::cmd_t     cmd_i,
  output sss_pkg::sts_t          sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sss_pkg::out_req_t      out_req_o
);

  `include "signed_int_seven_segment_scanner_top_defines.svh"

  logic [3:0]        codes_q [sss_pkg::NumDigits];
  logic [3:0]        codes_d [sss_pkg::NumDigits];
  logic              error_q, error_d;
  logic [1:0]        scan_q, scan_d;
  logic [15:0]       mag_q, mag_d;
  logic [2:0]        pos_q, pos_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  sss_pkg::out_req_t out_q, out_d;

  logic [15:0] mag_in;
  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] quot_x10;
  logic [3:0]  rem;
  logic [2:0]  limit;
  logic        mag_zero;
  logic        overflow;

  assign mag_in   = in_req_i.value[15] ? 16'(~in_req_i.value + 16'sd1) : in_req_i.value;
  assign prod     = 32'(mag_q) * 32'(sss_pkg::RECIP_TEN);
  assign quot     = prod[31:sss_pkg::RecipShift];
  assign quot_x10 = {quot[12:0], 3'b000} - 16'({quot, 3'b000}) + 16'({quot, 3'b000})
                    + 16'({quot, 1'b0});
  assign rem      = 4'(mag_q - quot_x10);
  assign limit    = neg_q ? sss_pkg::LIMIT_NEG : sss_pkg::LIMIT_POS;
  assign mag_zero = (mag_q == 16'd0);
  assign overflow = !mag_zero && (pos_q >= limit);

  assign sts_o.conv_last = cmd_i.conv_step && (mag_zero || overflow);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    codes_d     = codes_q;
    error_d     = error_q;
    scan_d      = scan_q;
    mag_d       = mag_q;
    pos_d       = pos_q;
    neg_d       = neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load_start) begin
      for (int i = 0; i < sss_pkg::NumDigits; i++) begin
        codes_d[i] = sss_pkg::CODE_BLANK;
      end
      mag_d = mag_in;
      neg_d = in_req_i.value[15];
      pos_d = 3'd0;
    end
    if (cmd_i.conv_step) begin
      if (mag_zero) begin
        if (pos_q == 3'd0) begin
          codes_d[0] = sss_pkg::CODE_ZERO;
        end else if (neg_q) begin
          codes_d[pos_q[1:0]] = sss_pkg::CODE_MINUS;
        end
        error_d = 1'b0;
      end else if (overflow) begin
        for (int i = 0; i < sss_pkg::NumDigits; i++) begin
          codes_d[i] = sss_pkg::CODE_BLANK;
        end
        error_d = 1'b1;
      end else begin
        codes_d[pos_q[1:0]] = rem;
        mag_d               = 16'(quot);
        pos_d               = pos_q + 3'd1;
      end
    end
    if (cmd_i.tick_fire) begin
      if (error_q) begin
        out_d.digit_select = sss_pkg::select_code(2'd0);
        out_d.segments     = sss_pkg::GLYPH_ERROR;
      end else begin
        out_d.digit_select = sss_pkg::select_code(scan_q);
        out_d.segments     = sss_pkg::seg_pattern(codes_q[scan_q]);
      end
      out_valid_d = 1'b1;
      scan_d      = scan_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sss_pkg::NumDigits; i++) begin
        codes_q[i] <= sss_pkg::CODE_ZERO;
      end
      error_q     <= 1'b0;
      scan_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      codes_q     <= codes_d;
      error_q     <= error_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    pos_q <= pos_d;
    neg_q <= neg_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `SSS_ASSERT(a_pos_bound, cmd_i.conv_step |-> (pos_q <= sss_pkg::LIMIT_POS),
              "digit position past limit")
  `SSS_ASSERT(a_error_blank,
              (error_q && !cmd_i.conv_step) |->
                (codes_q[0] == sss_pkg::CODE_BLANK && codes_q[1] == sss_pkg::CODE_BLANK
                 && codes_q[2] == sss_pkg::CODE_BLANK && codes_q[3] == sss_pkg::CODE_BLANK),
              "error mode with visible digits")
  `SSS_ASSERT_NEXT(a_tick_result, cmd_i.tick_fire, out_valid_q, "tick produced no request")

endmodule
`default_nettype wire
